// File: src/nte_pkg.sv
package nte_pkg;

   localparam int VALUE_W   = 50;
   localparam int WORD_W    = 6;
   localparam int NUM_DIGITS = 15;
   localparam int BCD_W     = 4 * NUM_DIGITS;
   localparam int GROUP_W   = 12;
   localparam int NUM_GROUPS = NUM_DIGITS / 3;
   localparam int CNT_W     = $clog2(VALUE_W + 1);
   localparam int GIDX_W    = $clog2(NUM_GROUPS);
   localparam int NUM_SLOTS = 5;
   localparam int SLOT_W    = $clog2(NUM_SLOTS + 1);

   localparam logic [VALUE_W-1:0] VALUE_MAX = 50'd999999999999999;

   localparam logic [WORD_W-1:0] WORD_TEN      = 6'd9;
   localparam logic [WORD_W-1:0] WORD_TWENTY   = 6'd19;
   localparam logic [WORD_W-1:0] WORD_HUNDRED  = 6'd27;
   localparam logic [WORD_W-1:0] WORD_TRILLION = 6'd31;
   localparam logic [WORD_W-1:0] WORD_NONE     = 6'd32;

   // token positions within one three-digit group
   localparam int SLOT_DIGIT   = 0;
   localparam int SLOT_HUNDRED = 1;
   localparam int SLOT_SMALL   = 2;
   localparam int SLOT_UNIT    = 3;
   localparam int SLOT_SCALE   = 4;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONV,
      ST_EMIT,
      ST_ZERO
   } state_type;

endpackage

// File: src/nte_dabble.sv
module nte_dabble
   import nte_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [VALUE_W-1:0] value,
   output logic               done,
   output logic [BCD_W-1:0]   bcd
);

   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [VALUE_W-1:0] bin_ff, bin_in;
   logic [BCD_W-1:0]   bcd_ff, bcd_in;
   logic               done_ff, done_in;
   logic [BCD_W-1:0]   adj;

   // add three to every digit of five or more before the shift
   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         if (bcd_ff[4*i +: 4] >= 4'd5) begin
            adj[4*i +: 4] = bcd_ff[4*i +: 4] + 4'd3;
         end else begin
            adj[4*i +: 4] = bcd_ff[4*i +: 4];
         end
      end
   end

   always_comb begin
      cnt_in  = cnt_ff;
      bin_in  = bin_ff;
      bcd_in  = bcd_ff;
      done_in = 1'b0;
      if (start) begin
         cnt_in = CNT_W'(VALUE_W);
         bin_in = (value > VALUE_MAX) ? VALUE_MAX : value;
         bcd_in = '0;
      end else if (cnt_ff != '0) begin
         cnt_in  = cnt_ff - 1'b1;
         bin_in  = {bin_ff[VALUE_W-2:0], 1'b0};
         bcd_in  = {adj[BCD_W-2:0], bin_ff[VALUE_W-1]};
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   assign done = done_ff;
   assign bcd  = bcd_ff;

endmodule

// File: src/number_to_english_words.sv
// Spells an unsigned number as a run of English short-scale word tokens.
// Input channel: req_valid / req_stall with req_value (50 bits); values above
// 999999999999999 are clamped to that value. Result channel: rsp_valid /
// rsp_stall with rsp_word and rsp_last, one word token per transaction,
// rsp_last high on the final token of a number. Zero gives the single token
// "none" with rsp_last set.
// One number is handled at a time: req_stall stays high from acceptance until
// the final token has been placed in the output register.
// A nonzero number passes through a bit-serial binary to BCD converter
// (one input bit per cycle), then its digits are loaded into the group
// register and the token sequencer emits its tokens, shifting on to the next
// three-digit group whenever the current group has no token left. Once the
// last token is registered, the next number can be accepted in the cycle after.
// The next number can be accepted while the last token still waits in the
// output register.
// When the receiver stalls, the output register holds its token and the
// token sequencer waits; nothing is dropped.
// Reset returns the block to idle with the output register empty.
module number_to_english_words
   import nte_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [VALUE_W-1:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [WORD_W-1:0]  rsp_word,
   output logic               rsp_last
);

   state_type state_ff, state_in;

   logic [BCD_W-1:0]  grp_ff, grp_in;
   logic [GIDX_W-1:0] gidx_ff, gidx_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0] rsp_word_ff, rsp_word_in;
   logic              rsp_last_ff, rsp_last_in;

   logic                  accept;
   logic                  is_zero;
   logic                  conv_done;
   logic [BCD_W-1:0]      conv_bcd;
   logic                  out_free;
   logic [3:0]            dig_h, dig_t, dig_u;
   logic [NUM_SLOTS-1:0]  slot_ok;
   logic [WORD_W-1:0]     slot_word [NUM_SLOTS];
   logic                  found;
   logic [SLOT_W-1:0]     pick;
   logic                  later;
   logic                  tok_last;
   logic                  emit_go;

   assign accept   = req_valid && !req_stall;
   assign is_zero  = (req_value == '0);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   nte_dabble u_dabble (
      .clock (clock),
      .reset (reset),
      .start (accept && !is_zero),
      .value (req_value),
      .done  (conv_done),
      .bcd   (conv_bcd)
   );

   // digits of the group at the top of the shift register
   assign dig_h = grp_ff[BCD_W-1 -: 4];
   assign dig_t = grp_ff[BCD_W-5 -: 4];
   assign dig_u = grp_ff[BCD_W-9 -: 4];

   always_comb begin
      slot_ok[SLOT_DIGIT]   = (dig_h != 4'd0);
      slot_ok[SLOT_HUNDRED] = (dig_h != 4'd0);
      slot_ok[SLOT_SMALL]   = (dig_t != 4'd0) || (dig_u != 4'd0);
      slot_ok[SLOT_UNIT]    = (dig_t >= 4'd2) && (dig_u != 4'd0);
      slot_ok[SLOT_SCALE]   = (grp_ff[BCD_W-1 -: GROUP_W] != '0) &&
                              (gidx_ff != GIDX_W'(NUM_GROUPS - 1));

      slot_word[SLOT_DIGIT]   = {2'b00, dig_h} - 6'd1;
      slot_word[SLOT_HUNDRED] = WORD_HUNDRED;
      if (dig_t == 4'd0) begin
         slot_word[SLOT_SMALL] = {2'b00, dig_u} - 6'd1;
      end else if (dig_t == 4'd1) begin
         slot_word[SLOT_SMALL] = WORD_TEN + {2'b00, dig_u};
      end else begin
         slot_word[SLOT_SMALL] = WORD_TWENTY + {2'b00, dig_t} - 6'd2;
      end
      slot_word[SLOT_UNIT]  = {2'b00, dig_u} - 6'd1;
      slot_word[SLOT_SCALE] = WORD_TRILLION - {{(WORD_W-GIDX_W){1'b0}}, gidx_ff};
   end

   // first pending slot at or after the current position
   always_comb begin
      found = 1'b0;
      pick  = '0;
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
         if (slot_ok[i] && (i >= int'(slot_ff))) begin
            found = 1'b1;
            pick  = SLOT_W'(i);
         end
      end
      later = 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         if (slot_ok[i] && (i > int'(pick))) begin
            later = 1'b1;
         end
      end
   end

   assign tok_last = !later && (grp_ff[BCD_W-GROUP_W-1:0] == '0);
   assign emit_go  = (state_ff == ST_EMIT) && found && out_free;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = is_zero ? ST_ZERO : ST_CONV;
            end
         end
         ST_CONV: begin
            if (conv_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (emit_go && tok_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_ZERO: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      grp_in       = grp_ff;
      gidx_in      = gidx_ff;
      slot_in      = slot_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_word_in  = rsp_word_ff;
      rsp_last_in  = rsp_last_ff;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
         end
         ST_CONV: begin
            req_stall = 1'b1;
            if (conv_done) begin
               grp_in  = conv_bcd;
               gidx_in = '0;
               slot_in = '0;
            end
         end
         ST_EMIT: begin
            req_stall = 1'b1;
            if (!found) begin
               grp_in  = {grp_ff[BCD_W-GROUP_W-1:0], {GROUP_W{1'b0}}};
               gidx_in = gidx_ff + 1'b1;
               slot_in = '0;
            end else if (out_free) begin
               slot_in      = pick + 1'b1;
               rsp_valid_in = 1'b1;
               rsp_word_in  = slot_word[pick];
               rsp_last_in  = tok_last;
            end
         end
         ST_ZERO: begin
            req_stall = 1'b1;
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = WORD_NONE;
               rsp_last_in  = 1'b1;
            end
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      grp_ff      <= grp_in;
      gidx_ff     <= gidx_in;
      slot_ff     <= slot_in;
      rsp_word_ff <= rsp_word_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;
   assign rsp_last  = rsp_last_ff;

`ifndef SYNTH
   a_done_in_conv: assert property (@(posedge clock) disable iff (reset)
      conv_done |-> (state_ff == ST_CONV))
      else $error("converter finished outside conversion");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_CONV) || (state_ff == ST_ZERO))
      else $error("accepted transaction did not start work");

   a_group_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (gidx_ff < GIDX_W'(NUM_GROUPS)))
      else $error("group index ran past the units group");

   a_none_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_word_ff == WORD_NONE)) |-> rsp_last_ff)
      else $error("none token without last flag");

   a_emit_needs_room: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> $stable(rsp_word_ff) && $stable(rsp_last_ff))
      else $error("stalled token overwritten");
`endif

endmodule

// File: dv/tb_top.sv
module tb_top;
   import nte_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_WORDS    = 24;
   localparam int RANDOM_ITEMS = 155;
   localparam int CYCLE_LIMIT  = 500000;

   typedef struct packed {
      logic [WORD_W-1:0] word;
      logic              last;
   } word_tok_type;

   class word_tracker;
      word_tok_type pending_words[$];
      word_tok_type spelled[$];
      int unsigned  errors;
      int unsigned  numbers;
      int unsigned  zeros;
      int unsigned  clamped;
      int unsigned  words_checked;
      bit           word_seen [0:32];

      function void push_word(logic [WORD_W-1:0] w);
         if (spelled.size() < MAX_WORDS) begin
            spelled.push_back('{word: w, last: 1'b0});
         end
      endfunction

      // one to nineteen, or a round ten from twenty to ninety
      function void spell_small(longint unsigned v);
         if (v >= 1 && v <= 19) begin
            push_word(WORD_W'(v - 1));
         end else if (v >= 20 && v <= 90 && v % 10 == 0) begin
            push_word(WORD_TWENTY + WORD_W'(v / 10 - 2));
         end
      endfunction

      function void spell_group(longint unsigned g);
         longint unsigned rest;
         if (g >= 100) begin
            spell_small(g / 100);
            push_word(WORD_HUNDRED);
         end
         rest = g % 100;
         if (rest % 10 == 0 || rest <= 20) begin
            spell_small(rest);
         end else begin
            spell_small(rest - rest % 10);
            spell_small(rest % 10);
         end
      endfunction

      function void note_number(logic [VALUE_W-1:0] v);
         longint unsigned x;
         longint unsigned scale;
         x = v;
         numbers++;
         spelled.delete();
         if (x > VALUE_MAX) begin
            x = VALUE_MAX;
            clamped++;
         end
         if (x == 0) begin
            zeros++;
            push_word(WORD_NONE);
         end else begin
            scale = 64'd1000000000000;
            for (int i = 0; i < 4; i++) begin
               if (x >= scale) begin
                  spell_group(x / scale);
                  push_word(WORD_TRILLION - WORD_W'(i));
                  x = x % scale;
               end
               scale = scale / 1000;
            end
            spell_group(x);
         end
         spelled[spelled.size() - 1].last = 1'b1;
         foreach (spelled[i]) pending_words.push_back(spelled[i]);
      endfunction

      function void check_word(logic [WORD_W-1:0] w, logic l);
         word_tok_type exp_tok;
         words_checked++;
         if (pending_words.size() == 0) begin
            $error("unexpected word token %0d (last %0b) with nothing pending", w, l);
            errors++;
            return;
         end
         exp_tok = pending_words.pop_front();
         if (w !== exp_tok.word) begin
            $error("field word: expected %0d, got %0d", exp_tok.word, w);
            errors++;
         end
         if (l !== exp_tok.last) begin
            $error("field last: expected %0b, got %0b", exp_tok.last, l);
            errors++;
         end
         if (w <= WORD_NONE) word_seen[w] = 1'b1;
      endfunction

      function int unsigned codes_seen();
         int unsigned n;
         n = 0;
         foreach (word_seen[i]) n += word_seen[i];
         return n;
      endfunction
   endclass

   logic               clock     = 1'b0;
   logic               reset     = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [VALUE_W-1:0] req_value = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [WORD_W-1:0]  rsp_word;
   logic               rsp_last;

   word_tracker sb = new();
   bit          quiet = 1'b0;
   int unsigned cycle_count = 0;

   number_to_english_words u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_value (req_value),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .rsp_last  (rsp_last)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words pending", cycle_count,
                  sb.pending_words.size());
         $display("number_to_english_words verification failed");
         $finish;
      end
   end

   // accepted transactions on both channels
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) sb.note_number(req_value);
      if (!reset && rsp_valid && !rsp_stall) sb.check_word(rsp_word, rsp_last);
   end

   // receiver: random stall before each word token
   initial begin
      int unsigned gap;
      wait (reset == 1'b0);
      forever begin
         gap = quiet ? 0 : $urandom_range(0, 14);
         @(negedge clock);
         if (gap > 0) begin
            rsp_stall = 1'b1;
            repeat (gap) @(negedge clock);
         end
         rsp_stall = 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_number(logic [VALUE_W-1:0] v);
      int unsigned gap;
      gap = quiet ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_value = v;
      do @(posedge clock); while (!(req_valid && !req_stall));
      @(negedge clock);
   endtask

   task automatic drain_words();
      req_valid = 1'b0;
      while (sb.pending_words.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic [VALUE_W-1:0] random_number();
      longint unsigned v;
      int unsigned     pick;
      pick = $urandom_range(0, 3);
      v = 0;
      case (pick)
         0: begin
            v = {$urandom, $urandom};
         end
         1: begin
            v = $urandom_range(0, 999);
         end
         2: begin
            // five groups, some of them zero
            for (int g = 0; g < 5; g++) begin
               v = v * 1000 + (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 999));
            end
         end
         default: begin
            v = $urandom_range(1, 999);
            repeat ($urandom_range(0, 4)) v = v * 1000;
         end
      endcase
      return VALUE_W'(v);
   endfunction

   logic [VALUE_W-1:0] directed_values[$] = '{
      50'd0, 50'd1, 50'd7, 50'd10, 50'd11, 50'd13, 50'd19, 50'd20, 50'd21,
      50'd45, 50'd99, 50'd100, 50'd101, 50'd110, 50'd119, 50'd999, 50'd1000,
      50'd1001, 50'd1000000, 50'd1000000000, 50'd1000000000000,
      50'd100000000000000, 50'd999999999999999, 50'd1000000000000000,
      50'h3FFFFFFFFFFFF
   };

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_values[i]) send_number(directed_values[i]);
      drain_words();

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         // back-to-back stretch with no idling on either side
         quiet = (n >= 70 && n < 100);
         if (n == 50 || n == 130) drain_words();
         send_number(random_number());
      end
      quiet = 1'b0;
      drain_words();
      repeat (100) @(posedge clock);

      $display("spelled %0d numbers (%0d zero, %0d clamped from above range)",
               sb.numbers, sb.zeros, sb.clamped);
      $display("checked %0d word tokens, %0d of 33 word codes seen",
               sb.words_checked, sb.codes_seen());
      if (sb.pending_words.size() != 0) begin
         $error("%0d word tokens never arrived", sb.pending_words.size());
         sb.errors++;
      end
      if (sb.errors == 0) begin
         $display("number_to_english_words verification clean");
      end else begin
         $display("number_to_english_words verification failed");
      end
      $finish;
   end

endmodule
